@@ sv/dnsle_pkg.sv @@
package dnsle_pkg;

  localparam int unsigned LenW      = 6;
  localparam int unsigned AddrW     = LenW + 1;
  localparam int unsigned MAX_LABEL = 63;

  localparam logic [7:0] CHAR_DOT = 8'd46;
  localparam logic [7:0] CHAR_END = 8'd0;

  typedef struct packed {
    logic            bank;
    logic [LenW-1:0] len;
    logic            ending;
    logic            ovf;
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

endpackage

@@ sv/dns_name_label_encoder_core.sv @@
// A closing dot or zero character enters the command queue; its length byte is loaded into
// the output register when the replay unit and the result side are free; each label byte
// follows through a store read and an output load. Throughput: one character per cycle
// is accepted until two closed labels wait for replay; these steps set the sustained
// rate. Reset clears all control state at once; the label store is not cleared and is only
// read at entries written within the same label.
module dns_name_label_encoder_core #(
  parameter int unsigned MaxLabel = dnsle_pkg::MAX_LABEL
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] name_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       end_of_name_o,
  output logic       label_overflow_o
);
  import dnsle_pkg::*;

  cmd_t             push_data;
  cmd_t             head;
  wr_req_t          wr;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata;

  dnsle_front #(
    .MaxLabel(MaxLabel)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .name_char_i (name_char_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data),
    .wr_o        (wr)
  );

  dnsle_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  dnsle_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dnsle_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (head),
    .q_empty_i        (q_empty),
    .pop_o            (pop),
    .raddr_o          (raddr),
    .rdata_i          (rdata),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o),
    .end_of_name_o    (end_of_name_o),
    .label_overflow_o (label_overflow_o)
  );

endmodule

@@ sv/dnsle_store.sv @@
module dnsle_store (
  input  logic                           clk_i,
  input  dnsle_pkg::wr_req_t             wr_i,
  input  logic [dnsle_pkg::AddrW-1:0]    raddr_i,
  output logic [7:0]                     rdata_o
);
  import dnsle_pkg::*;

  localparam int unsigned Depth = 1 << AddrW;

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/dnsle_cmd_fifo.sv @@
module dnsle_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dnsle_pkg::cmd_t push_data_i,
  input  logic            pop_i,
  output dnsle_pkg::cmd_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import dnsle_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Label command pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Label command popped from an empty queue.");
`endif

endmodule

@@ sv/dnsle_front.sv @@
module dnsle_front #(
  parameter int unsigned MaxLabel = dnsle_pkg::MAX_LABEL
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          name_char_i,
  input  logic                q_full_i,
  output logic                push_o,
  output dnsle_pkg::cmd_t     push_data_o,
  output dnsle_pkg::wr_req_t  wr_o
);
  import dnsle_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxLabel);

  logic [LenW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            bank_q, bank_d;
  logic            accept;
  logic            closing;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign closing    = (name_char_i == CHAR_DOT) || (name_char_i == CHAR_END);

  always_comb begin
    count_d            = count_q;
    ovf_d              = ovf_q;
    bank_d             = bank_q;
    push_o             = 1'b0;
    push_data_o.bank   = bank_q;
    push_data_o.len    = count_q;
    push_data_o.ending = (name_char_i == CHAR_END);
    push_data_o.ovf    = ovf_q;
    wr_o.we            = 1'b0;
    wr_o.addr          = {bank_q, count_q};
    wr_o.data          = name_char_i;
    if (accept) begin
      if (closing) begin
        push_o  = 1'b1;
        count_d = '0;
        ovf_d   = 1'b0;
        bank_d  = ~bank_q;
      end else if (count_q < MaxLen) begin
        wr_o.we = 1'b1;
        count_d = count_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      bank_q  <= bank_d;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= MaxLen)
    else $error("Label count exceeds the maximum label length.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (count_q == '0) && !ovf_q && (bank_q != $past(bank_q)))
    else $error("Label state not cleared after a label was closed.");
`endif

endmodule

@@ sv/dnsle_back.sv @@
module dnsle_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dnsle_pkg::cmd_t  cmd_i,
  input  logic             q_empty_i,
  output logic             pop_o,
  output logic [dnsle_pkg::AddrW-1:0] raddr_o,
  input  logic [7:0]       rdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  output logic             end_of_name_o,
  output logic             label_overflow_o
);
  import dnsle_pkg::*;

  localparam logic [1:0] ST_HEAD  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_DATA  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [LenW-1:0] idx_nxt;
  logic            out_free;
  logic            load;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic            end_q, end_d;
  logic            ovf_q, ovf_d;

  assign out_free = !valid_q || out_ready_i;
  assign idx_nxt  = idx_q + LenW'(1);
  assign raddr_o  = {cmd_i.bank, idx_q};

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    byte_d  = byte_q;
    last_d  = last_q;
    end_d   = end_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_HEAD: begin
        if (!q_empty_i && out_free) begin
          load   = 1'b1;
          byte_d = {2'b00, cmd_i.len};
          last_d = (cmd_i.len == '0);
          end_d  = cmd_i.ending && (cmd_i.len == '0);
          ovf_d  = cmd_i.ovf;
          idx_d  = '0;
          if (cmd_i.len == '0) begin
            pop_o = 1'b1;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_DATA;
      end
      ST_DATA: begin
        if (out_free) begin
          load   = 1'b1;
          byte_d = rdata_i;
          last_d = (idx_nxt == cmd_i.len);
          end_d  = cmd_i.ending && (idx_nxt == cmd_i.len);
          ovf_d  = cmd_i.ovf;
          idx_d  = idx_nxt;
          if (idx_nxt == cmd_i.len) begin
            pop_o   = 1'b1;
            state_d = ST_HEAD;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_HEAD;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEAD;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    end_q  <= end_d;
    ovf_q  <= ovf_d;
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = byte_q;
  assign last_of_run_o    = last_q;
  assign end_of_name_o    = end_q;
  assign label_overflow_o = ovf_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH || state_q == ST_DATA) |-> !q_empty_i && (idx_q < cmd_i.len))
    else $error("Label byte replay runs past the label length.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> load && last_d)
    else $error("Label command retired without its final byte.");
`endif

endmodule

@@ sim/tb_dns_name_label_encoder_core.sv @@
module tb_dns_name_label_encoder_core;
  import dnsle_pkg::*;

  typedef struct packed {
    logic [7:0] octet;
    logic       last_run;
    logic       name_end;
    logic       dropped;
  } wire_byte_t;

  // The scoreboard carries its own copy of the label state and predicts the wire bytes.
  class label_scoreboard;
    logic [7:0]  label_bytes [MAX_LABEL];
    int unsigned label_len;
    bit          chars_dropped;
    wire_byte_t  expected_bytes [$];
    int unsigned mismatches;

    function void note_char(logic [7:0] c);
      wire_byte_t wb;
      bit         ending;
      if (c != CHAR_DOT && c != CHAR_END) begin
        if (label_len < MAX_LABEL) begin
          label_bytes[label_len] = c;
          label_len++;
        end else begin
          chars_dropped = 1'b1;
        end
      end else begin
        ending = (c == CHAR_END);
        wb.octet    = 8'(label_len);
        wb.last_run = (label_len == 0);
        wb.name_end = ending && (label_len == 0);
        wb.dropped  = chars_dropped;
        expected_bytes.push_back(wb);
        for (int unsigned i = 0; i < label_len; i++) begin
          wb.octet    = label_bytes[i];
          wb.last_run = (i + 1 == label_len);
          wb.name_end = ending && (i + 1 == label_len);
          wb.dropped  = chars_dropped;
          expected_bytes.push_back(wb);
        end
        label_len     = 0;
        chars_dropped = 1'b0;
      end
    endfunction

    function void check_byte(wire_byte_t got);
      wire_byte_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output byte=%0d last=%0b end=%0b ovf=%0b",
                   got.octet, got.last_run, got.name_end, got.dropped);
        end
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"mismatch: expected byte=%0d last=%0b end=%0b ovf=%0b, ",
                      "got byte=%0d last=%0b end=%0b ovf=%0b"},
                     want.octet, want.last_run, want.name_end, want.dropped,
                     got.octet, got.last_run, got.name_end, got.dropped);
          end
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] name_char_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       end_of_name_o;
  logic       label_overflow_o;

  label_scoreboard sb = new();
  int unsigned     chars_accepted;
  logic            calm;
  logic            hold_rx;

  dns_name_label_encoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .name_char_i     (name_char_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .end_of_name_o   (end_of_name_o),
    .label_overflow_o(label_overflow_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic send_char(input logic [7:0] c);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    name_char_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_char(c);
    chars_accepted++;
  endtask

  task automatic send_label(input int unsigned len);
    logic [7:0] c;
    for (int unsigned i = 0; i < len; i++) begin
      c = 8'($urandom_range(1, 255));
      if (c == CHAR_DOT) begin
        c = 8'h2d;
      end
      send_char(c);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_byte({out_byte_o, last_of_run_o, end_of_name_o, label_overflow_o});
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_ready_i <= 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 14);
      end
    end
  end

  // The receiver stops for a long stretch so that the block fills and stalls its input.
  initial begin
    hold_rx <= 1'b0;
    wait (chars_accepted >= 300);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #3000000;
    $display("dns_name_label_encoder_core verification failed");
    $finish;
  end

  initial begin
    int unsigned names_sent;
    int unsigned n_labels;
    int unsigned len;
    int unsigned roll;
    int unsigned guard;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    name_char_i <= 8'h00;
    calm        <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed names: empty labels in every position, extreme characters, full and
    // overflowing labels.
    send_char(CHAR_END);
    send_char(CHAR_DOT);
    send_char(8'h61);
    send_char(CHAR_END);
    send_char(8'h61);
    send_char(CHAR_DOT);
    send_char(CHAR_DOT);
    send_char(8'h62);
    send_char(CHAR_DOT);
    send_char(CHAR_END);
    send_char(8'h01);
    send_char(8'hff);
    send_char(8'h2d);
    send_char(8'h2f);
    send_char(8'h80);
    send_char(8'h7f);
    send_char(CHAR_END);
    send_label(MAX_LABEL);
    send_char(CHAR_DOT);
    send_label(MAX_LABEL + 1);
    send_char(CHAR_END);
    send_label(80);
    send_char(CHAR_DOT);
    send_char(8'h78);
    send_char(CHAR_END);

    names_sent = 0;
    while (chars_accepted < 360) begin
      if (names_sent == 1) begin
        calm <= 1'b1;
      end else if (names_sent == 5) begin
        calm <= 1'b0;
      end
      if ($urandom_range(99) < 85) begin
        n_labels = $urandom_range(1, 4);
        for (int unsigned l = 0; l < n_labels; l++) begin
          roll = $urandom_range(99);
          if (roll < 10) begin
            len = 0;
          end else if (roll < 13) begin
            len = $urandom_range(55, 70);
          end else begin
            len = $urandom_range(1, 12);
          end
          send_label(len);
          send_char((l == n_labels - 1) ? CHAR_END : CHAR_DOT);
        end
      end else begin
        n_labels = $urandom_range(1, 8);
        for (int unsigned i = 0; i < n_labels; i++) begin
          roll = $urandom_range(99);
          if (roll < 10) begin
            send_char(CHAR_DOT);
          end else if (roll < 20) begin
            send_char(CHAR_END);
          end else begin
            send_char(8'($urandom_range(0, 255)));
          end
        end
      end
      names_sent++;
    end
    in_valid_i <= 1'b0;
    calm       <= 1'b0;

    guard = 0;
    while (sb.expected_bytes.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("dns_name_label_encoder_core verification clean");
    end else begin
      $display("dns_name_label_encoder_core verification failed");
    end
    $finish;
  end

endmodule
